[rtl/core/pom_pkg.sv]
package pom_pkg;

  // Most results a single execute beat may produce.
  localparam int MAX_RESULTS = 16;
  localparam int TRADE_CNT_W = $clog2(MAX_RESULTS);

  typedef enum logic {
    OP_ADD     = 1'b0,
    OP_EXECUTE = 1'b1
  } op_t;

  typedef enum logic {
    SIDE_SELL = 1'b0,
    SIDE_BUY  = 1'b1
  } side_t;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_TRADE    = 2'd2,
    KIND_NO_TRADE = 2'd3
  } kind_t;

  // One resting order.
  typedef struct packed {
    logic [31:0] price;
    logic [31:0] quantity;
    logic [15:0] trader_id;
  } order_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;
    logic trade;
    logic no_trade;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_free;
    logic match_head;
    logic match_next;
  } status_t;

endpackage

[rtl/core/price_priority_order_matcher.sv]
// Channel    Direction  Handshake                Payload
// s_*        in         s_tvalid / s_tready      order or execute request
// m_*        out        m_tvalid / m_tready      add answer, trade or no-trade
// cfg_*      in         cfg_valid / cfg_ready    instrument code
//
// An add beat's answer lands in the result register in the next cycle.
// An execute beat yields 1 to 16 trade results, or one no-trade result,
// paced by the single best-bid/best-ask compare.
// A stalled m_tready holds the controller; s_tready stays low while matching.
// Reset clears both book fill counts and the instrument code; book storage
// needs no clearing pass.
module price_priority_order_matcher #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [87:0]   s_tdata,   // side, price, quantity, trader_id, zero pad
  input  logic [0:0]    s_tuser,   // operation
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // buyer_id, seller_id, trade_quantity,
                                   // trade_price, instrument
  output logic [1:0]    m_tuser,   // kind
  output logic          m_tlast,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import pom_pkg::*;

  logic [15:0] instrument_id;
  cmd_t        cmd;
  status_t     status;
  order_t      in_order;
  kind_t       res_kind;
  logic [15:0] res_buyer, res_seller;
  logic [31:0] res_quantity, res_price;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      instrument_id <= '0;
    end else if (cfg_valid) begin
      instrument_id <= cfg_data;
    end
  end

  // Unpack the request beat.
  assign in_order.price     = s_tdata[32:1];
  assign in_order.quantity  = s_tdata[64:33];
  assign in_order.trader_id = s_tdata[80:65];

  pom_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (op_t'(s_tuser[0])),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  pom_datapath #(.DEPTH(BOOK_DEPTH)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_order     (in_order),
    .in_side      (side_t'(s_tdata[0])),
    .m_tready     (m_tready),
    .status       (status),
    .res_valid    (m_tvalid),
    .res_kind     (res_kind),
    .res_buyer    (res_buyer),
    .res_seller   (res_seller),
    .res_quantity (res_quantity),
    .res_price    (res_price),
    .res_last     (m_tlast)
  );

  // Pack the result beat.
  assign m_tuser = res_kind;
  assign m_tdata = {instrument_id, res_price, res_quantity, res_seller, res_buyer};

`ifndef SYNTHESIS
  // An execute beat keeps the input closed for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == OP_EXECUTE)) |=> !s_tready)
    else $error("input reopened right after an execute beat");

  // An add beat always produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser[0] == OP_ADD)) |=> m_tvalid)
    else $error("add beat produced no result");

  // Add answers and no-trade results are single-beat answers.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_TRADE)) |-> m_tlast)
    else $error("non-trade result without last");
`endif

endmodule

[rtl/core/pom_book.sv]
module pom_book #(
  parameter int DEPTH = 16,
  parameter bit DESC  = 1'b1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            insert,
  input  logic            pop,
  input  pom_pkg::order_t new_order,
  output pom_pkg::order_t head,
  output pom_pkg::order_t second,
  output logic            full,
  output logic            has_one,
  output logic            has_two
);
  import pom_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]    count;
  order_t           entry [DEPTH];
  logic [DEPTH-1:0] behind;

  // Each cell holds one order; the book stays sorted, so the cells that keep
  // their place on an insert form a prefix. Ties stay ahead of the new order.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign behind[i] = (CW'(i) < count) &&
                       (DESC ? (entry[i].price >= new_order.price)
                             : (entry[i].price <= new_order.price));

    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (insert && !behind[i]) begin
          entry[i] <= new_order;
        end else if (pop) begin
          if (DEPTH > 1) begin
            entry[i] <= entry[(DEPTH > 1) ? 1 : 0];
          end
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (insert && !behind[i]) begin
          entry[i] <= behind[i-1] ? new_order : entry[i-1];
        end else if (pop && (i < DEPTH - 1)) begin
          entry[i] <= entry[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Fill count; entries at or above it hold no order and never affect a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (insert) begin
      count <= count + 1'b1;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  assign head    = entry[0];
  assign full    = (count == CW'(DEPTH));
  assign has_one = (count != '0);

  // The second entry gives the lookahead for the last flag of a trade.
  if (DEPTH > 1) begin : g_second
    assign second  = entry[(DEPTH > 1) ? 1 : 0];
    assign has_two = (count > CW'(1));
  end else begin : g_no_second
    assign second  = '0;
    assign has_two = 1'b0;
  end

endmodule

[rtl/core/pom_datapath.sv]
module pom_datapath #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  pom_pkg::cmd_t    cmd,
  input  pom_pkg::order_t  in_order,
  input  pom_pkg::side_t   in_side,
  input  logic             m_tready,
  output pom_pkg::status_t status,
  output logic             res_valid,
  output pom_pkg::kind_t   res_kind,
  output logic [15:0]      res_buyer,
  output logic [15:0]      res_seller,
  output logic [31:0]      res_quantity,
  output logic [31:0]      res_price,
  output logic             res_last
);
  import pom_pkg::*;

  order_t bid_head, bid_second, ask_head, ask_second;
  logic   bid_full, bid_has_one, bid_has_two;
  logic   ask_full, ask_has_one, ask_has_two;
  logic   bid_insert, ask_insert, add_ok;

  // A full book drops the order and answers rejected.
  assign bid_insert = cmd.add && (in_side == SIDE_BUY) && !bid_full;
  assign ask_insert = cmd.add && (in_side == SIDE_SELL) && !ask_full;
  assign add_ok     = (in_side == SIDE_BUY) ? !bid_full : !ask_full;

  pom_book #(.DEPTH(DEPTH), .DESC(1'b1)) u_bid (
    .clk       (clk),
    .rst       (rst),
    .insert    (bid_insert),
    .pop       (cmd.trade),
    .new_order (in_order),
    .head      (bid_head),
    .second    (bid_second),
    .full      (bid_full),
    .has_one   (bid_has_one),
    .has_two   (bid_has_two)
  );

  pom_book #(.DEPTH(DEPTH), .DESC(1'b0)) u_ask (
    .clk       (clk),
    .rst       (rst),
    .insert    (ask_insert),
    .pop       (cmd.trade),
    .new_order (in_order),
    .head      (ask_head),
    .second    (ask_second),
    .full      (ask_full),
    .has_one   (ask_has_one),
    .has_two   (ask_has_two)
  );

  // Crossing tests on the best orders and on the ones just behind them.
  assign status.match_head = bid_has_one && ask_has_one &&
                             (bid_head.price >= ask_head.price);
  assign status.match_next = bid_has_two && ask_has_two &&
                             (bid_second.price >= ask_second.price);
  assign status.res_free   = !res_valid || m_tready;

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      res_kind     <= add_ok ? KIND_ACCEPTED : KIND_REJECTED;
      res_buyer    <= '0;
      res_seller   <= '0;
      res_quantity <= '0;
      res_price    <= '0;
      res_last     <= 1'b1;
    end else if (cmd.trade) begin
      res_kind     <= KIND_TRADE;
      res_buyer    <= bid_head.trader_id;
      res_seller   <= ask_head.trader_id;
      res_quantity <= bid_head.quantity;
      res_price    <= ask_head.price;
      res_last     <= cmd.last;
    end else if (cmd.no_trade) begin
      res_kind     <= KIND_NO_TRADE;
      res_buyer    <= '0;
      res_seller   <= '0;
      res_quantity <= '0;
      res_price    <= '0;
      res_last     <= 1'b1;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.add || cmd.trade || cmd.no_trade) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/pom_ctrl.sv]
module pom_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  pom_pkg::op_t     op,
  input  pom_pkg::status_t status,
  output logic             s_tready,
  output pom_pkg::cmd_t    cmd
);
  import pom_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_MATCH = 2'b10
  } state_t;

  state_t                 state, state_next;
  logic [TRADE_CNT_W-1:0] trade_cnt, trade_cnt_next;

  // New beats are taken only between items and when the result slot frees.
  assign s_tready = (state == S_IDLE) && status.res_free;

  // Next state and commands.
  always_comb begin
    state_next     = state;
    trade_cnt_next = trade_cnt;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (op == OP_ADD) begin
            cmd.add = 1'b1;
          end else begin
            state_next     = S_MATCH;
            trade_cnt_next = '0;
          end
        end
      end
      S_MATCH: begin
        if (status.res_free) begin
          if (status.match_head) begin
            cmd.trade = 1'b1;
            cmd.last  = !status.match_next ||
                        (trade_cnt == TRADE_CNT_W'(MAX_RESULTS - 1));
            if (cmd.last) begin
              state_next = S_IDLE;
            end else begin
              trade_cnt_next = trade_cnt + 1'b1;
            end
          end else begin
            cmd.no_trade = 1'b1;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      trade_cnt <= '0;
    end else begin
      state     <= state_next;
      trade_cnt <= trade_cnt_next;
    end
  end

endmodule
